/* hw/rtl/assert_macros.svh */
// Assertion macros used by the RTL top level.
// Each macro samples on posedge clk and is disabled while rst_n is low;
// the including module must provide clk and rst_n.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check that a condition holds in the same cycle.
`define ASSERT_NOW(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hw/rtl/emta_pkg.sv */
// Package for the exposure midpoint time adjust block: item types,
// timing constants, reciprocal constants and the leap-day function.
// No dependencies.
`default_nettype none

package emta_pkg;

    localparam int EPOCH_YEAR      = 1901;
    localparam int CENTURY_YEAR    = 2000;
    localparam int DAYS_PER_YEAR   = 365;
    localparam int SECS_PER_DAY    = 86400;
    localparam int SECS_PER_HOUR   = 3600;
    localparam int SECS_PER_MIN    = 60;
    localparam int TICKS_PER_SEC   = 20000;
    localparam int TICKS_PER_MILLI = 20;
    localparam int GUARD_TICKS     = 2;

    // Reciprocals: floor(x / d) = (x * RECIP) >> SHIFT, exact over the stated input width.
    localparam int EXPO_RECIP  = 27487791;  // d = 20000, x < 2^24, shift 39
    localparam int MILLI_RECIP = 52429;     // d = 20,    x < 2^15, shift 20
    localparam int HOUR_RECIP  = 149131;    // d = 3600,  x < 2^17, shift 29
    localparam int MIN_RECIP   = 4370;      // d = 60,    x < 2^12, shift 18
    localparam int YEAR_RECIP  = 1470880;   // d = 365,   x < 2^20, shift 29
    localparam int CENT_RECIP  = 5243;      // d = 100,   x < 2^12, shift 19

    typedef struct packed {
        logic [11:0] year_in;
        logic [8:0]  day_in;
        logic [4:0]  hour_in;
        logic [5:0]  minute_in;
        logic [5:0]  second_in;
        logic [9:0]  milli_in;
        logic        milli_valid;
        logic [23:0] exposure_tenths;
    } in_item_t;

    typedef struct packed {
        logic [11:0] year_out;
        logic [8:0]  day_out;
        logic [4:0]  hour_out;
        logic [5:0]  minute_out;
        logic [5:0]  second_out;
        logic [9:0]  milli_out;
        logic        milli_valid_out;
    } out_item_t;

    // Leap-day term (y-1901)/4 - (y-2000)/100 + (y-2000)/400, each quotient
    // truncated toward zero. Valid for year offsets of magnitude below 4096.
    function automatic logic signed [11:0] leap_days(input logic signed [13:0] year);
        logic signed [13:0] off_epoch;
        logic signed [13:0] off_cent;
        logic [11:0]        mag_epoch;
        logic [11:0]        mag_cent;
        logic [24:0]        prod100;
        logic [24:0]        prod400;
        logic signed [11:0] t4;
        logic signed [11:0] t100;
        logic signed [11:0] t400;
        off_epoch = year - 14'(EPOCH_YEAR);
        off_cent  = year - 14'(CENTURY_YEAR);
        mag_epoch = off_epoch[13] ? 12'(-off_epoch) : 12'(off_epoch);
        mag_cent  = off_cent[13] ? 12'(-off_cent) : 12'(off_cent);
        prod100   = 25'(mag_cent) * 25'(CENT_RECIP);
        prod400   = 25'(mag_cent[11:2]) * 25'(CENT_RECIP);
        t4        = $signed({2'b00, mag_epoch[11:2]});
        t100      = $signed({6'd0, prod100[24:19]});
        t400      = $signed({6'd0, prod400[24:19]});
        if (off_epoch[13])
        begin
            t4 = -t4;
        end
        if (off_cent[13])
        begin
            t100 = -t100;
            t400 = -t400;
        end
        return t4 - t100 + t400;
    endfunction

endpackage

`default_nettype wire

/* hw/rtl/emta_stream_if.sv */
// Valid/ready stream channel carrying one item per handshake.
// The payload type is a parameter; no package dependency.
`default_nettype none

interface emta_stream_if #(
    parameter type T = logic
) ();
    logic valid;
    logic ready;
    T     payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

/* hw/rtl/exposure_midpoint_time_adjust.sv */
// Exposure midpoint time adjust: seven-stage pipeline, top level.
// Depends on emta_pkg, emta_stream_if and assert_macros.svh.
//
// Usage:
//   in_ch carries one shutter-close timestamp plus exposure time per item
//   (emta_pkg::in_item_t); out_ch returns the timestamp moved back by half
//   the exposure (emta_pkg::out_item_t), one result item per input item,
//   in order. An item moves when valid and ready are both high.
//   Each accepted item passes through the stage registers in order; its
//   result is valid on out_ch once it reaches the output register.
//   Throughput: one item per cycle while out_ch.ready stays high; every
//   stage is a register with its own valid bit, and the depth is set by
//   the constant-reciprocal multipliers, each followed by a register.
//   Reset (rst_n low, asynchronous) clears the stage valid bits, so the
//   pipeline comes up empty with in_ch.ready high.
//   When the receiver stalls, the output register holds its item and the
//   stages behind it keep filling their empty slots; in_ch.ready falls only
//   once every stage holds an item.
`default_nettype none

`include "assert_macros.svh"

module exposure_midpoint_time_adjust (
    input  wire            clk,
    input  wire            rst_n,
    emta_stream_if.sink    in_ch,
    emta_stream_if.source  out_ch
);
    import emta_pkg::*;

    localparam int NUM_STAGES = 7;

    logic [NUM_STAGES-1:0] vld_reg;
    logic [NUM_STAGES-1:0] vld_next;
    logic [NUM_STAGES-1:0] stage_rdy;

    // Stage 1: day count, second of day, exposure split into whole seconds.
    logic signed [21:0] days1_reg, days1_next;
    logic [16:0]        sod1_reg, sod1_next;
    logic [9:0]         eq1_reg, eq1_next;
    logic [23:0]        expo1_reg;
    logic [9:0]         milli1_reg, milli1_next;
    logic               mv1_reg;
    logic signed [13:0] yr_in_s;
    logic signed [13:0] yr_off_s;
    logic [48:0]        expo_prod;

    // Stage 2: tick and second differences before normalization.
    logic signed [16:0] tick2_reg, tick2_next;
    logic signed [17:0] sec2_reg, sec2_next;
    logic signed [21:0] days2_reg;
    logic               mv2_reg;
    logic [23:0]        er_full;

    // Stage 3: normalized ticks, second of day, day count.
    logic [14:0]        tick3_reg, tick3_next;
    logic [16:0]        sec3_reg, sec3_next;
    logic [19:0]        days3_reg, days3_next;
    logic               mv3_reg;
    logic               tick_lo, tick_hi, sec_lo, sec_hi;
    logic signed [16:0] tick_adj;
    logic signed [17:0] sec_c, sec_adj;
    logic signed [21:0] days_adj;

    // Stage 4: millisecond, hour, whole years.
    logic [9:0]         ms4_reg, ms4_next;
    logic [4:0]         hour4_reg, hour4_next;
    logic [16:0]        sec4_reg;
    logic [11:0]        yq4_reg, yq4_next;
    logic [19:0]        days4_reg;
    logic               mv4_reg;
    logic [14:0]        frac_raw, frac;
    logic [30:0]        milli_prod;
    logic [34:0]        hour_prod;
    logic [40:0]        year_prod;

    // Stage 5: seconds within the hour, day of year for both year choices.
    logic [11:0]        rem5_reg, rem5_next;
    logic [11:0]        yr5_reg;
    logic signed [21:0] dd_hi5_reg, dd_hi5_next;
    logic signed [21:0] dd_lo5_reg, dd_lo5_next;
    logic [9:0]         ms5_reg;
    logic [4:0]         hour5_reg;
    logic               mv5_reg;
    logic [16:0]        rem_full;
    logic signed [13:0] yr_hi, yr_lo;
    logic signed [11:0] leap_hi, leap_lo;

    // Stage 6: minute, final year and day.
    logic [5:0]         min6_reg, min6_next;
    logic [11:0]        rem6_reg;
    logic [11:0]        year6_reg, year6_next;
    logic [8:0]         day6_reg, day6_next;
    logic [9:0]         ms6_reg;
    logic [4:0]         hour6_reg;
    logic               mv6_reg;
    logic [24:0]        min_prod;
    logic               step_back;

    // Stage 7: output register.
    out_item_t          out_reg, out_next;
    logic [11:0]        sec_full;

    // ------------------------------------------------------------------
    // Flow control: a stage loads when it is empty or its item moves on.
    // ------------------------------------------------------------------
    always_comb
    begin
        stage_rdy[NUM_STAGES-1] = !vld_reg[NUM_STAGES-1] || out_ch.ready;
        for (int k = NUM_STAGES - 2; k >= 0; k--)
        begin
            stage_rdy[k] = !vld_reg[k] || stage_rdy[k+1];
        end
        vld_next = {vld_reg[NUM_STAGES-2:0], in_ch.valid};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            for (int k = 0; k < NUM_STAGES; k++)
            begin
                if (stage_rdy[k])
                begin
                    vld_reg[k] <= vld_next[k];
                end
            end
        end
    end

    assign in_ch.ready    = stage_rdy[0];
    assign out_ch.valid   = vld_reg[NUM_STAGES-1];
    assign out_ch.payload = out_reg;

    // ------------------------------------------------------------------
    // Stage 1: count days since the epoch and split the exposure into
    // whole seconds; drop the millisecond when it is not given.
    // ------------------------------------------------------------------
    always_comb
    begin
        yr_in_s     = $signed({2'b00, in_ch.payload.year_in});
        yr_off_s    = yr_in_s - 14'(EPOCH_YEAR);
        days1_next  = 22'($signed({1'b0, in_ch.payload.day_in}))
                    + 22'(yr_off_s) * 22'(DAYS_PER_YEAR)
                    + 22'(leap_days(yr_in_s));
        sod1_next   = 17'(in_ch.payload.second_in)
                    + 17'(in_ch.payload.minute_in) * 17'(SECS_PER_MIN)
                    + 17'(in_ch.payload.hour_in) * 17'(SECS_PER_HOUR);
        expo_prod   = 49'(in_ch.payload.exposure_tenths) * 49'(EXPO_RECIP);
        eq1_next    = expo_prod[48:39];
        milli1_next = in_ch.payload.milli_valid ? in_ch.payload.milli_in : '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[0])
        begin
            days1_reg  <= days1_next;
            sod1_reg   <= sod1_next;
            eq1_reg    <= eq1_next;
            expo1_reg  <= in_ch.payload.exposure_tenths;
            milli1_reg <= milli1_next;
            mv1_reg    <= in_ch.payload.milli_valid;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: subtract the exposure in mixed radix (seconds, ticks).
    // One exposure unit halved is one 0.05 ms tick.
    // ------------------------------------------------------------------
    always_comb
    begin
        er_full    = expo1_reg - 24'(eq1_reg) * 24'(TICKS_PER_SEC);
        tick2_next = 17'(milli1_reg) * 17'(TICKS_PER_MILLI) - 17'(er_full[14:0]);
        sec2_next  = 18'(sod1_reg) - 18'(eq1_reg);
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[1])
        begin
            tick2_reg <= tick2_next;
            sec2_reg  <= sec2_next;
            days2_reg <= days1_reg;
            mv2_reg   <= mv1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: carry ticks into seconds and seconds into days, one step
    // each; clamp a time before the epoch to zero.
    // ------------------------------------------------------------------
    always_comb
    begin
        tick_lo  = tick2_reg < 17'sd0;
        tick_hi  = tick2_reg >= 17'(TICKS_PER_SEC);
        tick_adj = tick_lo ? tick2_reg + 17'(TICKS_PER_SEC)
                 : tick_hi ? tick2_reg - 17'(TICKS_PER_SEC)
                 : tick2_reg;
        sec_c    = sec2_reg + (tick_lo ? -18'sd1 : (tick_hi ? 18'sd1 : 18'sd0));
        sec_lo   = sec_c < 18'sd0;
        sec_hi   = sec_c >= 18'(SECS_PER_DAY);
        sec_adj  = sec_lo ? sec_c + 18'(SECS_PER_DAY)
                 : sec_hi ? sec_c - 18'(SECS_PER_DAY)
                 : sec_c;
        days_adj = days2_reg + (sec_lo ? -22'sd1 : (sec_hi ? 22'sd1 : 22'sd0));
        if (days_adj < 22'sd0)
        begin
            tick3_next = '0;
            sec3_next  = '0;
            days3_next = '0;
        end
        else
        begin
            tick3_next = tick_adj[14:0];
            sec3_next  = sec_adj[16:0];
            days3_next = days_adj[19:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[2])
        begin
            tick3_reg <= tick3_next;
            sec3_reg  <= sec3_next;
            days3_reg <= days3_next;
            mv3_reg   <= mv2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: millisecond with the two-tick guard, hour, whole years.
    // ------------------------------------------------------------------
    always_comb
    begin
        frac_raw   = tick3_reg + 15'(GUARD_TICKS);
        frac       = (frac_raw >= 15'(TICKS_PER_SEC)) ? frac_raw - 15'(TICKS_PER_SEC)
                                                      : frac_raw;
        milli_prod = 31'(frac) * 31'(MILLI_RECIP);
        ms4_next   = mv3_reg ? milli_prod[29:20] : '0;
        hour_prod  = 35'(sec3_reg) * 35'(HOUR_RECIP);
        hour4_next = hour_prod[33:29];
        year_prod  = 41'(days3_reg) * 41'(YEAR_RECIP);
        yq4_next   = year_prod[40:29];
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[3])
        begin
            ms4_reg   <= ms4_next;
            hour4_reg <= hour4_next;
            sec4_reg  <= sec3_reg;
            yq4_reg   <= yq4_next;
            days4_reg <= days3_reg;
            mv4_reg   <= mv3_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: seconds left in the hour; day of year for the estimated
    // year and for the year before it.
    // ------------------------------------------------------------------
    always_comb
    begin
        rem_full    = sec4_reg - 17'(hour4_reg) * 17'(SECS_PER_HOUR);
        rem5_next   = rem_full[11:0];
        yr_hi       = 14'(yq4_reg) + 14'(EPOCH_YEAR);
        yr_lo       = yr_hi - 14'sd1;
        leap_hi     = leap_days(yr_hi);
        leap_lo     = leap_days(yr_lo);
        dd_hi5_next = 22'(days4_reg) - 22'(yq4_reg) * 22'(DAYS_PER_YEAR) - 22'(leap_hi);
        dd_lo5_next = dd_hi5_next + 22'(DAYS_PER_YEAR) + 22'(leap_hi) - 22'(leap_lo);
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[4])
        begin
            rem5_reg   <= rem5_next;
            yr5_reg    <= yr_hi[11:0];
            dd_hi5_reg <= dd_hi5_next;
            dd_lo5_reg <= dd_lo5_next;
            ms5_reg    <= ms4_reg;
            hour5_reg  <= hour4_reg;
            mv5_reg    <= mv4_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: minute; step the year back once if the day fell below 1.
    // ------------------------------------------------------------------
    always_comb
    begin
        min_prod   = 25'(rem5_reg) * 25'(MIN_RECIP);
        min6_next  = min_prod[23:18];
        step_back  = dd_hi5_reg < 22'sd1;
        year6_next = step_back ? yr5_reg - 12'd1 : yr5_reg;
        day6_next  = step_back ? dd_lo5_reg[8:0] : dd_hi5_reg[8:0];
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[5])
        begin
            min6_reg  <= min6_next;
            rem6_reg  <= rem5_reg;
            year6_reg <= year6_next;
            day6_reg  <= day6_next;
            ms6_reg   <= ms5_reg;
            hour6_reg <= hour5_reg;
            mv6_reg   <= mv5_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 7: whole second; assemble the result item.
    // ------------------------------------------------------------------
    always_comb
    begin
        sec_full                 = rem6_reg - 12'(min6_reg) * 12'(SECS_PER_MIN);
        out_next.year_out        = year6_reg;
        out_next.day_out         = day6_reg;
        out_next.hour_out        = hour6_reg;
        out_next.minute_out      = min6_reg;
        out_next.second_out      = sec_full[5:0];
        out_next.milli_out       = ms6_reg;
        out_next.milli_valid_out = mv6_reg;
    end

    always_ff @(posedge clk)
    begin
        if (stage_rdy[6])
        begin
            out_reg <= out_next;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    logic norm_ok;
    logic clock_ok;
    logic milli_ok;

    assign norm_ok  = tick3_reg < 15'(TICKS_PER_SEC) && sec3_reg < 17'(SECS_PER_DAY);
    assign clock_ok = out_ch.payload.hour_out < 5'd24 && out_ch.payload.minute_out < 6'd60
                   && out_ch.payload.second_out < 6'd60;
    assign milli_ok = out_ch.payload.milli_valid_out || out_ch.payload.milli_out == 10'd0;

    `ASSERT_NEXT(a_accept_loads, in_ch.valid && in_ch.ready, vld_reg[0], "item not in stage 1")
    `ASSERT_NOW(a_norm_range, !vld_reg[2] || norm_ok, "stage 3 ticks or seconds out of range")
    `ASSERT_NOW(a_clock_range, !out_ch.valid || clock_ok, "result clock field out of range")
    `ASSERT_NOW(a_milli_zero, !out_ch.valid || milli_ok, "millisecond not zero when invalid")

endmodule

`default_nettype wire
